[rtl/core/button_debounce_long_press_assert.svh]
// Assertion helpers shared by the debouncer RTL.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDLP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDLP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/bdlp_pkg.sv]
`timescale 1ns / 1ps
package bdlp_pkg;

    // counter and register width
    localparam int CNT_W = 16;

    // register indexes
    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_REPEAT     = 1'b1;

    // register reset values
    localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd20;
    localparam logic [CNT_W-1:0] REPEAT_RST     = 16'd5;

    // live configuration seen by every lane
    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } t_cfg;

    // per-button status after a tick update
    typedef struct packed {
        logic pressed;
        logic long_f;
        logic hold;
    } t_lane_stat;

endpackage

[rtl/core/bdlp_lane.sv]
`timescale 1ns / 1ps
module bdlp_lane import bdlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_pin,
    input  logic       i_clear,
    input  t_cfg       i_cfg,
    output t_lane_stat o_stat
);

    logic             r_newest, r_older, r_stable, r_long, r_hold;
    logic [CNT_W-1:0] r_press, r_repeat;
    logic             n_stable, n_long, n_hold;
    logic [CNT_W-1:0] n_press, n_repeat;
    logic [CNT_W-1:0] rep_inc;

    assign rep_inc = r_repeat + 1'b1;

    // one tick of debounce, press timing and auto-repeat
    always_comb begin
        n_stable = ((i_pin == r_newest) && (r_newest == r_older)) ? i_pin : r_stable;
        n_press  = r_press;
        n_repeat = r_repeat;
        n_long   = r_long;
        n_hold   = r_hold & ~i_clear;
        if (!n_stable) begin
            if (r_press < i_cfg.long_press_ticks) begin
                n_press = r_press + 1'b1;
            end else begin
                n_long = 1'b1;
                if (r_repeat < i_cfg.repeat_ticks) begin
                    // below the limit, so the increment can reach it but never pass it
                    if (rep_inc == i_cfg.repeat_ticks) begin
                        n_repeat = '0;
                        n_hold   = 1'b1;
                    end else begin
                        n_repeat = rep_inc;
                    end
                end
            end
        end else begin
            n_press  = '0;
            n_repeat = '0;
            n_long   = 1'b0;
            n_hold   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= 1'b1;
            r_older  <= 1'b1;
            r_stable <= 1'b1;
            r_press  <= '0;
            r_repeat <= '0;
            r_long   <= 1'b0;
            r_hold   <= 1'b0;
        end else if (i_accept) begin
            r_newest <= i_pin;
            r_older  <= r_newest;
            r_stable <= n_stable;
            r_press  <= n_press;
            r_repeat <= n_repeat;
            r_long   <= n_long;
            r_hold   <= n_hold;
        end
    end

    // status as it stands after this tick
    assign o_stat.pressed = ~n_stable;
    assign o_stat.long_f  = n_long;
    assign o_stat.hold    = n_hold;

endmodule

[rtl/core/bdlp_merge.sv]
`timescale 1ns / 1ps
module bdlp_merge import bdlp_pkg::*; #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_lane_stat             i_stat [NUM_BUTTONS],
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output logic [NUM_BUTTONS-1:0] o_pressed_mask,
    output logic [NUM_BUTTONS-1:0] o_long_press_mask,
    output logic [NUM_BUTTONS-1:0] o_hold_mask
);

    logic [NUM_BUTTONS-1:0] n_pressed, n_long, n_hold;
    logic                   r_out_valid, r_skid_valid;
    logic [NUM_BUTTONS-1:0] r_out_pressed, r_out_long, r_out_hold;
    logic [NUM_BUTTONS-1:0] r_skid_pressed, r_skid_long, r_skid_hold;
    logic                   out_take;

    // gather lane results into masks
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_pressed[i] = i_stat[i].pressed;
            n_long[i]    = i_stat[i].long_f;
            n_hold[i]    = i_stat[i].hold;
        end
    end

    assign out_take   = r_out_valid & i_out_ready;
    assign o_in_ready = ~r_skid_valid;

    // output register plus skid beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_accept) begin
                r_out_valid <= 1'b1;
                if (r_out_valid && !i_out_ready) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_pressed <= r_skid_pressed;
                r_out_long    <= r_skid_long;
                r_out_hold    <= r_skid_hold;
            end
        end else if (i_accept) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_pressed <= n_pressed;
                r_skid_long    <= n_long;
                r_skid_hold    <= n_hold;
            end else begin
                r_out_pressed <= n_pressed;
                r_out_long    <= n_long;
                r_out_hold    <= n_hold;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pressed_mask    = r_out_pressed;
    assign o_long_press_mask = r_out_long;
    assign o_hold_mask       = r_out_hold;

endmodule

[rtl/core/button_debounce_long_press.sv]
`timescale 1ns / 1ps
// Button debouncer with long-press and auto-repeat flags. Each input beat is one
// timer tick carrying the raw active-low pin levels and a mask of hold flags to
// clear; each tick yields one output beat with the pressed, long-press and hold
// masks after that tick's update. A new tick is taken every clock while input ready
// is high: one lane per button updates its three-sample history, press counter and
// repeat counter, and the result is registered in the output register, or in the
// skid register while the output is stalled. A two-beat output buffer keeps input
// ready high while one result waits; input is held off only once both hold one.
// APB registers: long_press_ticks at 0x0 and repeat_ticks at 0x4, 16 bits each.
`include "button_debounce_long_press_assert.svh"
module button_debounce_long_press import bdlp_pkg::*; #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tick input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [NUM_BUTTONS-1:0] i_pin_levels,
    input  logic [NUM_BUTTONS-1:0] i_clear_hold,
    // status output
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [NUM_BUTTONS-1:0] o_pressed_mask,
    output logic [NUM_BUTTONS-1:0] o_long_press_mask,
    output logic [NUM_BUTTONS-1:0] o_hold_mask,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg       r_cfg;
    t_lane_stat lane_stat [NUM_BUTTONS];
    logic       in_accept;
    logic       cfg_wr;
    logic       reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_wr    = psel & penable & pwrite;
    assign in_accept = i_in_valid & o_in_ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.repeat_ticks     <= REPEAT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_LONG_PRESS: r_cfg.long_press_ticks <= pwdata[CNT_W-1:0];
                REG_REPEAT:     r_cfg.repeat_ticks     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_LONG_PRESS: prdata = {{(32-CNT_W){1'b0}}, r_cfg.long_press_ticks};
            REG_REPEAT:     prdata = {{(32-CNT_W){1'b0}}, r_cfg.repeat_ticks};
            default:        prdata = '0;
        endcase
    end

    // one lane per button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdlp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (in_accept),
            .i_pin    (i_pin_levels[g]),
            .i_clear  (i_clear_hold[g]),
            .i_cfg    (r_cfg),
            .o_stat   (lane_stat[g])
        );
    end

    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_stat            (lane_stat),
        .i_out_ready       (i_out_ready),
        .o_in_ready        (o_in_ready),
        .o_out_valid       (o_out_valid),
        .o_pressed_mask    (o_pressed_mask),
        .o_long_press_mask (o_long_press_mask),
        .o_hold_mask       (o_hold_mask)
    );

    // hold implies long press implies pressed
    `BDLP_ASSERT_IMP(a_flag_order, i_clk, i_rst_n, o_out_valid, ((o_hold_mask & ~o_long_press_mask) == '0) && ((o_long_press_mask & ~o_pressed_mask) == '0), "flag order broken")
    // a full buffer always has a beat on the output
    `BDLP_ASSERT_IMP(a_skid_full, i_clk, i_rst_n, !o_in_ready, o_out_valid, "skid holds beat with output empty")
    // a tick taken behind a stalled result fills the skid
    `BDLP_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n, in_accept && o_out_valid && !i_out_ready, !o_in_ready && o_out_valid, "stalled beat not buffered")

endmodule
